FILE: src/lmbc_pkg.sv
`default_nettype none

package lmbc_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 16;
  localparam int unsigned CFG_W           = 16;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned DUTY_W          = 8;
  localparam int unsigned INTERVAL_W      = 16;
  localparam int unsigned STEP_W          = 8;

  localparam logic [DUTY_W-1:0] DUTY_FULL = 8'd255;
  localparam logic [DUTY_W-1:0] DUTY_ZERO = 8'd0;

  localparam logic [INTERVAL_W-1:0] DEBOUNCE_RST       = 16'd50;
  localparam logic [INTERVAL_W-1:0] BLINK_INTERVAL_RST = 16'd300;
  localparam logic [INTERVAL_W-1:0] BREATH_INTERVAL_RST = 16'd15;
  localparam logic [STEP_W-1:0]     BREATH_STEP_RST    = 8'd5;

  typedef enum logic [1:0] {
    LIGHT_OFF   = 2'd0,
    LIGHT_ON    = 2'd1,
    LIGHT_BLINK = 2'd2,
    LIGHT_PULSE = 2'd3
  } light_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE        = 2'd0,
    CFG_BLINK_INTERVAL  = 2'd1,
    CFG_BREATH_INTERVAL = 2'd2,
    CFG_BREATH_STEP     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [INTERVAL_W-1:0] debounce_ms;
    logic [INTERVAL_W-1:0] blink_interval_ms;
    logic [INTERVAL_W-1:0] breathe_interval_ms;
    logic [STEP_W-1:0]     breathe_step;
  } cfg_t;

endpackage

`default_nettype wire

FILE: src/lmbc_debounce.sv
`default_nettype none

module lmbc_debounce #(
  parameter int unsigned CountWidth = lmbc_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              step_i,
  input  wire logic                              raw_i,
  input  wire logic [lmbc_pkg::INTERVAL_W-1:0]   debounce_ms_i,
  output logic                                   stable_d_o,
  output logic                                   press_o
);

  localparam int unsigned CmpW =
    (CountWidth > lmbc_pkg::INTERVAL_W) ? CountWidth : lmbc_pkg::INTERVAL_W;

  logic                  last_raw_q;
  logic                  stable_q, stable_d;
  logic [CountWidth-1:0] cnt_q, cnt_d;
  logic                  accept;

  always_comb begin
    if (raw_i != last_raw_q) begin
      cnt_d = '0;
    end else if (cnt_q == {CountWidth{1'b1}}) begin
      cnt_d = cnt_q;
    end else begin
      cnt_d = cnt_q + 1'b1;
    end
    accept   = (CmpW'(cnt_d) > CmpW'(debounce_ms_i)) && (raw_i != stable_q);
    stable_d = accept ? raw_i : stable_q;
  end

  assign stable_d_o = stable_d;
  assign press_o    = accept && !raw_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q <= 1'b1;
      stable_q   <= 1'b1;
      cnt_q      <= '0;
    end else if (step_i) begin
      last_raw_q <= raw_i;
      stable_q   <= stable_d;
      cnt_q      <= cnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/lmbc_effect.sv
`default_nettype none

module lmbc_effect #(
  parameter int unsigned CountWidth = lmbc_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            step_i,
  input  wire logic                            press_i,
  input  wire lmbc_pkg::cfg_t                  cfg_i,
  output logic [lmbc_pkg::DUTY_W-1:0]          duty_d_o,
  output lmbc_pkg::light_mode_e                mode_d_o
);

  localparam int unsigned CmpW =
    (CountWidth > lmbc_pkg::INTERVAL_W) ? CountWidth : lmbc_pkg::INTERVAL_W;

  lmbc_pkg::light_mode_e mode_q, mode_d;
  logic [CountWidth-1:0] blink_cnt_q, blink_cnt_d;
  logic [CountWidth-1:0] breath_cnt_q, breath_cnt_d;
  logic                  blink_on_q, blink_on_d;
  logic [lmbc_pkg::DUTY_W-1:0] bright_q, bright_d;
  logic                  rising_q, rising_d;
  logic [lmbc_pkg::DUTY_W-1:0] duty_q, duty_d;
  logic signed [9:0]     level;

  always_comb begin
    mode_d       = mode_q;
    blink_cnt_d  = (blink_cnt_q == {CountWidth{1'b1}}) ? blink_cnt_q : blink_cnt_q + 1'b1;
    breath_cnt_d = (breath_cnt_q == {CountWidth{1'b1}}) ? breath_cnt_q : breath_cnt_q + 1'b1;
    blink_on_d   = blink_on_q;
    bright_d     = bright_q;
    rising_d     = rising_q;
    duty_d       = duty_q;
    level        = '0;

    if (press_i) begin
      mode_d       = lmbc_pkg::light_mode_e'(mode_q + 2'd1);
      blink_on_d   = 1'b0;
      bright_d     = '0;
      rising_d     = 1'b1;
      blink_cnt_d  = '0;
      breath_cnt_d = '0;
    end

    case (mode_d)
      lmbc_pkg::LIGHT_OFF: begin
        duty_d = lmbc_pkg::DUTY_ZERO;
      end
      lmbc_pkg::LIGHT_ON: begin
        duty_d = lmbc_pkg::DUTY_FULL;
      end
      lmbc_pkg::LIGHT_BLINK: begin
        if (CmpW'(blink_cnt_d) >= CmpW'(cfg_i.blink_interval_ms)) begin
          blink_cnt_d = '0;
          blink_on_d  = !blink_on_d;
          duty_d      = blink_on_d ? lmbc_pkg::DUTY_FULL : lmbc_pkg::DUTY_ZERO;
        end
      end
      lmbc_pkg::LIGHT_PULSE: begin
        if (CmpW'(breath_cnt_d) >= CmpW'(cfg_i.breathe_interval_ms)) begin
          breath_cnt_d = '0;
          if (rising_d) begin
            level = $signed({2'b00, bright_d}) + $signed({2'b00, cfg_i.breathe_step});
          end else begin
            level = $signed({2'b00, bright_d}) - $signed({2'b00, cfg_i.breathe_step});
          end
          if (level >= 10'sd255) begin
            level    = 10'sd255;
            rising_d = 1'b0;
          end
          if (level <= 10'sd0) begin
            level    = 10'sd0;
            rising_d = 1'b1;
          end
          bright_d = level[lmbc_pkg::DUTY_W-1:0];
          duty_d   = level[lmbc_pkg::DUTY_W-1:0];
        end
      end
      default: begin
        duty_d = duty_q;
      end
    endcase
  end

  assign duty_d_o = duty_d;
  assign mode_d_o = mode_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= lmbc_pkg::LIGHT_OFF;
      blink_cnt_q  <= '0;
      breath_cnt_q <= '0;
      blink_on_q   <= 1'b0;
      bright_q     <= '0;
      rising_q     <= 1'b1;
      duty_q       <= '0;
    end else if (step_i) begin
      mode_q       <= mode_d;
      blink_cnt_q  <= blink_cnt_d;
      breath_cnt_q <= breath_cnt_d;
      blink_on_q   <= blink_on_d;
      bright_q     <= bright_d;
      rising_q     <= rising_d;
      duty_q       <= duty_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/led_mode_button_controller_unit.sv
`default_nettype none

// channel | valid       | stall        | payload
// --------+-------------+--------------+--------------------------------------
// in      | in_valid_i  | in_stall_o   | button_level_i
// out     | out_valid_o | out_stall_i  | duty_o, light_mode_o, button_stable_o
// cfg     | cfg_we_i    | none         | cfg_index_i, cfg_data_i
//
// one tick per cycle while in_stall_o is low; a result is registered and appears in the cycle after its tick is taken
// the result register is set by the tick transfer, so in_stall_o is high only
// while a result is held and out_stall_i is high
// reset clears all state and loads the register defaults

module led_mode_button_controller_unit #(
  parameter int unsigned CountWidth = lmbc_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic                            button_level_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [7:0]                           duty_o,
  output logic [1:0]                           light_mode_o,
  output logic                                 button_stable_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [lmbc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [lmbc_pkg::CFG_W-1:0]      cfg_data_i
);

  lmbc_pkg::cfg_t        cfg_q;
  logic                  out_valid_q;
  logic [7:0]            duty_q;
  logic [1:0]            mode_q;
  logic                  stable_q;
  logic                  step;
  logic                  press;
  logic                  stable_d;
  logic [7:0]            duty_d;
  lmbc_pkg::light_mode_e mode_d;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign step       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms         <= lmbc_pkg::DEBOUNCE_RST;
      cfg_q.blink_interval_ms   <= lmbc_pkg::BLINK_INTERVAL_RST;
      cfg_q.breathe_interval_ms <= lmbc_pkg::BREATH_INTERVAL_RST;
      cfg_q.breathe_step        <= lmbc_pkg::BREATH_STEP_RST;
    end else if (cfg_we_i) begin
      case (lmbc_pkg::cfg_idx_e'(cfg_index_i))
        lmbc_pkg::CFG_DEBOUNCE:        cfg_q.debounce_ms         <= cfg_data_i;
        lmbc_pkg::CFG_BLINK_INTERVAL:  cfg_q.blink_interval_ms   <= cfg_data_i;
        lmbc_pkg::CFG_BREATH_INTERVAL: cfg_q.breathe_interval_ms <= cfg_data_i;
        lmbc_pkg::CFG_BREATH_STEP:     cfg_q.breathe_step        <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  lmbc_debounce #(
    .CountWidth(CountWidth)
  ) u_debounce (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .raw_i         (button_level_i),
    .debounce_ms_i (cfg_q.debounce_ms),
    .stable_d_o    (stable_d),
    .press_o       (press)
  );

  lmbc_effect #(
    .CountWidth(CountWidth)
  ) u_effect (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .press_i  (press),
    .cfg_i    (cfg_q),
    .duty_d_o (duty_d),
    .mode_d_o (mode_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q   <= '0;
      mode_q   <= '0;
      stable_q <= 1'b1;
    end else if (step) begin
      duty_q   <= duty_d;
      mode_q   <= mode_d;
      stable_q <= stable_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign duty_o          = duty_q;
  assign light_mode_o    = mode_q;
  assign button_stable_o = stable_q;

endmodule

`default_nettype wire

FILE: sim/tb_led_mode_button_controller_unit.sv
`timescale 1ns / 100ps

module tb_led_mode_button_controller_unit;

  localparam int QUIET_LIMIT = 2000;
  localparam int SEG_TICKS   = 200;

  typedef logic [lmbc_pkg::COUNT_WIDTH_DEF-1:0] count_t;

  typedef struct packed {
    logic [lmbc_pkg::DUTY_W-1:0] duty;
    lmbc_pkg::light_mode_e       mode;
    logic                        stable;
  } led_out_t;

  class led_tracker;
    logic [lmbc_pkg::INTERVAL_W-1:0] debounce_ms;
    logic [lmbc_pkg::INTERVAL_W-1:0] blink_iv;
    logic [lmbc_pkg::INTERVAL_W-1:0] breathe_iv;
    logic [lmbc_pkg::STEP_W-1:0]     step;

    lmbc_pkg::light_mode_e       mode;
    logic                        last_raw;
    logic                        stable;
    count_t                      deb_cnt;
    count_t                      blink_cnt;
    count_t                      breathe_cnt;
    logic                        blink_on;
    logic [lmbc_pkg::DUTY_W-1:0] bright;
    logic                        rising;
    logic [lmbc_pkg::DUTY_W-1:0] duty;

    led_out_t expected_leds[$];
    int       faults;

    function new();
      debounce_ms = lmbc_pkg::DEBOUNCE_RST;
      blink_iv    = lmbc_pkg::BLINK_INTERVAL_RST;
      breathe_iv  = lmbc_pkg::BREATH_INTERVAL_RST;
      step        = lmbc_pkg::BREATH_STEP_RST;
      mode        = lmbc_pkg::LIGHT_OFF;
      last_raw    = 1'b1;
      stable      = 1'b1;
      deb_cnt     = '0;
      blink_cnt   = '0;
      breathe_cnt = '0;
      blink_on    = 1'b0;
      bright      = '0;
      rising      = 1'b1;
      duty        = lmbc_pkg::DUTY_ZERO;
      faults      = 0;
    endfunction

    function void set_reg(lmbc_pkg::cfg_idx_e idx, logic [lmbc_pkg::CFG_W-1:0] val);
      case (idx)
        lmbc_pkg::CFG_DEBOUNCE:        debounce_ms = val;
        lmbc_pkg::CFG_BLINK_INTERVAL:  blink_iv = val;
        lmbc_pkg::CFG_BREATH_INTERVAL: breathe_iv = val;
        default:                       step = val[lmbc_pkg::STEP_W-1:0];
      endcase
    endfunction

    function count_t sat_inc(count_t c);
      return (c == '1) ? c : c + 1'b1;
    endfunction

    function void take_tick(logic raw);
      int b;
      led_out_t res;
      blink_cnt   = sat_inc(blink_cnt);
      breathe_cnt = sat_inc(breathe_cnt);
      deb_cnt     = (raw != last_raw) ? '0 : sat_inc(deb_cnt);
      if (deb_cnt > debounce_ms && raw != stable) begin
        stable = raw;
        if (!stable) begin
          case (mode)
            lmbc_pkg::LIGHT_OFF:   mode = lmbc_pkg::LIGHT_ON;
            lmbc_pkg::LIGHT_ON:    mode = lmbc_pkg::LIGHT_BLINK;
            lmbc_pkg::LIGHT_BLINK: mode = lmbc_pkg::LIGHT_PULSE;
            default:               mode = lmbc_pkg::LIGHT_OFF;
          endcase
          blink_on    = 1'b0;
          bright      = '0;
          rising      = 1'b1;
          blink_cnt   = '0;
          breathe_cnt = '0;
        end
      end
      last_raw = raw;
      case (mode)
        lmbc_pkg::LIGHT_OFF: duty = lmbc_pkg::DUTY_ZERO;
        lmbc_pkg::LIGHT_ON:  duty = lmbc_pkg::DUTY_FULL;
        lmbc_pkg::LIGHT_BLINK: begin
          if (blink_cnt >= blink_iv) begin
            blink_cnt = '0;
            blink_on  = ~blink_on;
            duty      = blink_on ? lmbc_pkg::DUTY_FULL : lmbc_pkg::DUTY_ZERO;
          end
        end
        default: begin
          if (breathe_cnt >= breathe_iv) begin
            breathe_cnt = '0;
            b = rising ? int'(bright) + int'(step) : int'(bright) - int'(step);
            if (b >= 255) begin
              b = 255;
              rising = 1'b0;
            end
            if (b <= 0) begin
              b = 0;
              rising = 1'b1;
            end
            bright = b[lmbc_pkg::DUTY_W-1:0];
            duty   = bright;
          end
        end
      endcase
      res.duty   = duty;
      res.mode   = mode;
      res.stable = stable;
      expected_leds.push_back(res);
    endfunction

    function void check_led(logic [lmbc_pkg::DUTY_W-1:0] d, logic [1:0] m, logic s);
      led_out_t exp_led;
      if (expected_leds.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("unexpected result: duty %0d mode %0d stable %0b", d, m, s);
        return;
      end
      exp_led = expected_leds.pop_front();
      if (exp_led.duty !== d || exp_led.mode !== m || exp_led.stable !== s) begin
        faults++;
        if (faults <= 10)
          $display("mismatch (exp/got): duty %0d/%0d mode %0d/%0d stable %0b/%0b",
                   exp_led.duty, d, exp_led.mode, m, exp_led.stable, s);
      end
    endfunction

    function int pending();
      return expected_leds.size();
    endfunction
  endclass

  logic                           clk_i          = 1'b0;
  logic                           rst_ni         = 1'b0;
  logic                           in_valid_i     = 1'b0;
  logic                           button_level_i = 1'b1;
  logic                           out_stall_i    = 1'b0;
  logic                           cfg_we_i       = 1'b0;
  logic [lmbc_pkg::CFG_IDX_W-1:0] cfg_index_i    = lmbc_pkg::CFG_DEBOUNCE;
  logic [lmbc_pkg::CFG_W-1:0]     cfg_data_i     = '0;
  logic                           in_stall_o;
  logic                           out_valid_o;
  logic [7:0]                     duty_o;
  logic [1:0]                     light_mode_o;
  logic                           button_stable_o;

  led_tracker leds;
  int idle_pct  = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  led_mode_button_controller_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .button_level_i (button_level_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .duty_o         (duty_o),
    .light_mode_o   (light_mode_o),
    .button_stable_o(button_stable_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        leds.check_led(duty_o, light_mode_o, button_stable_o);
      if (in_valid_i && !in_stall_o)
        leds.take_tick(button_level_i);
    end
    if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_led_mode_button_controller_unit: errors");
      $finish;
    end
  end

  task automatic send_tick(input logic lvl);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    button_level_i <= lvl;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic hold_level(input logic lvl, input int n);
    repeat (n) send_tick(lvl);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (leds.pending() != 0);
  endtask

  task automatic load_settings(input logic [lmbc_pkg::CFG_W-1:0] deb,
                               input logic [lmbc_pkg::CFG_W-1:0] blk,
                               input logic [lmbc_pkg::CFG_W-1:0] brt,
                               input logic [lmbc_pkg::CFG_W-1:0] stp);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= lmbc_pkg::CFG_DEBOUNCE;
    cfg_data_i  <= deb;
    @(posedge clk_i);
    cfg_index_i <= lmbc_pkg::CFG_BLINK_INTERVAL;
    cfg_data_i  <= blk;
    @(posedge clk_i);
    cfg_index_i <= lmbc_pkg::CFG_BREATH_INTERVAL;
    cfg_data_i  <= brt;
    @(posedge clk_i);
    cfg_index_i <= lmbc_pkg::CFG_BREATH_STEP;
    cfg_data_i  <= stp;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    leds.set_reg(lmbc_pkg::CFG_DEBOUNCE, deb);
    leds.set_reg(lmbc_pkg::CFG_BLINK_INTERVAL, blk);
    leds.set_reg(lmbc_pkg::CFG_BREATH_INTERVAL, brt);
    leds.set_reg(lmbc_pkg::CFG_BREATH_STEP, stp);
  endtask

  initial begin
    logic [21:0] opening;
    int deb;
    int sent;
    int r;
    int len;
    int k;
    leds = new();
    opening = 22'b11_00_11_000_11_0000_101_1_00;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // register defaults after reset
    hold_level(1'b1, 2);
    drain();
    load_settings(16'd0, 16'd0, 16'd0, 16'h00ff);
    for (int i = 21; i >= 0; i--) send_tick(opening[i]);
    drain();

    // long debounce window: the level is not taken
    load_settings(16'hffff, 16'hffff, 16'hffff, 16'hab00);
    hold_level(1'b1, 2);
    hold_level(1'b0, 200);
    drain();
    load_settings(16'hfffe, 16'hffff, 16'hffff, 16'h0000);
    hold_level(1'b0, 3);
    hold_level(1'b1, 3);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 61; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 61; end
        default: begin idle_pct = 21; stall_pct = 21; end
      endcase
      for (int s = 0; s < 2; s++) begin
        k = 2 * p + s;
        drain();
        case (k)
          0: load_settings(16'd0, 16'd0, 16'd0, 16'h00ff);
          1: load_settings(16'd1, 16'd1, 16'd1, 16'h0001);
          2: load_settings(lmbc_pkg::DEBOUNCE_RST, 16'd7, 16'd3, 16'h5a00);
          default: load_settings(16'($urandom_range(4)), 16'($urandom_range(8)),
                                 16'($urandom_range(6)),
                                 {8'($urandom), 8'($urandom_range(255))});
        endcase
        deb  = int'(leds.debounce_ms);
        sent = 0;
        while (sent < SEG_TICKS) begin
          r = $urandom_range(99);
          if (r < 75) begin
            // clean press then release, sometimes held long
            len = deb + 2 + (($urandom_range(3) == 0) ? $urandom_range(60) : $urandom_range(3));
            hold_level(1'b0, len);
            sent += len;
            len = deb + 2 + (($urandom_range(3) == 0) ? $urandom_range(60) : $urandom_range(3));
            hold_level(1'b1, len);
            sent += len;
          end else if (r < 90) begin
            // bounce cut short of the debounce window
            len = $urandom_range(deb + 1);
            hold_level(1'($urandom), len);
            sent += len;
          end else begin
            send_tick(1'($urandom));
            sent++;
          end
        end
      end
    end

    drain();
    repeat (4) @(posedge clk_i);
    if (leds.faults == 0 && leds.pending() == 0)
      $display("tb_led_mode_button_controller_unit: clean");
    else
      $display("tb_led_mode_button_controller_unit: errors");
    $finish;
  end

endmodule
